[rtl/core/ksel_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksel_pkg
// Shared constants and types of the k-smallest selection chain.
// ----------------------------------------------------------------------------
package ksel_pkg;

  // chain depth and longest vector that is compared
  localparam int MAX_K   = 32;
  localparam int MAX_LEN = 65536;

  // field widths
  localparam int VAL_W = 32;
  localparam int POS_W = 17;
  localparam int K_W   = 6;
  // index into the chain
  localparam int IDX_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;

  // one input item
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last_item;
  } ksel_in_t;

  // one result item
  typedef struct packed {
    logic signed [VAL_W-1:0] kept_value;
    logic [POS_W-1:0]        position;
    logic                    final_result;
    logic                    short_vector;
    logic                    too_long;
  } ksel_out_t;

  // one kept entry held by a cell
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } ksel_entry_t;

  // control broadcast from the top to every cell
  typedef struct packed {
    logic        accept;  // input item taken this cycle
    logic        ins_en;  // item is compared and may be inserted
    logic        last;    // item ends the vector
    logic        pop;     // result item taken this cycle
    ksel_entry_t fresh;   // the new entry
  } ksel_bcast_t;

endpackage

[rtl/core/k_smallest_select.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_smallest_select
// Streaming selection of the k smallest values of a vector.
// ----------------------------------------------------------------------------
// Values stream in one item per cycle while in_ready_o is high into a chain
// of MAX_K cells that keeps the k smallest entries sorted by value, then by
// position; every cell compares against the new key in the same cycle and
// shifts toward its neighbor, so input items are taken back to back. When the
// item marked last is taken, the chain is copied in parallel into an output
// chain and clears for the next vector; the results then leave one per cycle
// while out_ready_i is high, ascending, the final one marked. Further items of
// the next vector are taken while results drain, but its last item waits
// until all results (at most k) have left the output chain. k must be written
// only while idle; the block does not enforce this. 0 acts as 1 and values
// above MAX_K as MAX_K. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module k_smallest_select
  import ksel_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [K_W-1:0] cfg_wdata_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ksel_in_t       in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ksel_out_t      out_o
);

  logic [K_W-1:0]   k_q;
  logic [K_W-1:0]   cap;
  logic [K_W-1:0]   cap_m1;
  logic [POS_W-1:0] seen_q, seen_d;
  logic             ovf_q, ovf_d;
  logic             ovf_now;
  logic             short_q, too_long_q;
  logic             accept, pop, load;
  ksel_bcast_t      bcast;

  ksel_entry_t      entry_w    [MAX_K+1];
  logic             gt_w       [MAX_K+1];
  logic             mv_w       [MAX_K+1];
  ksel_entry_t      out_entry_w[MAX_K+1];
  logic             out_valid_w[MAX_K+1];
  logic [MAX_K-1:0] en_vec, nv_vec, valid_vec, out_vec;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= K_W'(1);
    end else if (cfg_we_i) begin
      k_q <= cfg_wdata_i;
    end
  end

  // effective k
  always_comb begin
    if (k_q == '0) begin
      cap = K_W'(1);
    end else if (k_q > K_W'(MAX_K)) begin
      cap = K_W'(MAX_K);
    end else begin
      cap = k_q;
    end
  end
  assign cap_m1 = cap - K_W'(1);

  // handshakes
  assign in_ready_o = ~(in_i.last_item & out_valid_w[0]);
  assign accept     = in_valid_i & in_ready_o;
  assign pop        = out_valid_w[0] & out_ready_i;
  assign load       = accept & in_i.last_item;
  assign ovf_now    = (seen_q == POS_W'(MAX_LEN));

  // broadcast to the chain
  always_comb begin
    bcast.accept         = accept;
    bcast.ins_en         = ~ovf_now;
    bcast.last           = in_i.last_item;
    bcast.pop            = pop;
    bcast.fresh.value    = in_i.value;
    bcast.fresh.position = seen_q + POS_W'(1);
  end

  // element count and overflow flag
  always_comb begin
    seen_d = seen_q;
    ovf_d  = ovf_q;
    if (accept) begin
      if (in_i.last_item) begin
        seen_d = '0;
        ovf_d  = 1'b0;
      end else if (ovf_now) begin
        ovf_d = 1'b1;
      end else begin
        seen_d = seen_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      ovf_q  <= 1'b0;
    end else begin
      seen_q <= seen_d;
      ovf_q  <= ovf_d;
    end
  end

  // vector flags, captured with the output chain
  always_ff @(posedge clk_i) begin
    if (load) begin
      short_q    <= ~nv_vec[cap_m1[IDX_W-1:0]];
      too_long_q <= ovf_q | ovf_now;
    end
  end

  // chain ends
  assign entry_w[0]           = '0;
  assign gt_w[0]              = 1'b0;
  assign mv_w[0]              = 1'b1;
  assign out_entry_w[MAX_K]   = '0;
  assign out_valid_w[MAX_K]   = 1'b0;

  // row of cells
  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    assign en_vec[i] = (cap > K_W'(i));

    ksel_cell u_cell (
      .clk_i            (clk_i),
      .rst_ni           (rst_ni),
      .bcast_i          (bcast),
      .en_i             (en_vec[i]),
      .prev_entry_i     (entry_w[i]),
      .prev_gt_i        (gt_w[i]),
      .prev_mv_i        (mv_w[i]),
      .next_out_entry_i (out_entry_w[i+1]),
      .next_out_valid_i (out_valid_w[i+1]),
      .entry_o          (entry_w[i+1]),
      .gt_o             (gt_w[i+1]),
      .mv_o             (mv_w[i+1]),
      .nv_o             (nv_vec[i]),
      .valid_o          (valid_vec[i]),
      .out_entry_o      (out_entry_w[i]),
      .out_valid_o      (out_valid_w[i])
    );

    assign out_vec[i] = out_valid_w[i];
  end

  // result item from the head of the output chain
  assign out_valid_o         = out_valid_w[0];
  assign out_o.kept_value    = out_entry_w[0].value;
  assign out_o.position      = out_entry_w[0].position;
  assign out_o.final_result  = ~out_valid_w[1];
  assign out_o.short_vector  = short_q;
  assign out_o.too_long      = too_long_q;

  // kept entries always form a prefix of the chain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot({1'b0, valid_vec} + {{MAX_K{1'b0}}, 1'b1}))
    else $error("kept entries do not form a prefix");

  // pending results always form a prefix of the output chain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot({1'b0, out_vec} + {{MAX_K{1'b0}}, 1'b1}))
    else $error("pending results do not form a prefix");

  // the output chain is only loaded when empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> !out_valid_w[0])
    else $error("output chain loaded while results pending");

  // a finished vector always yields at least one result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_o)
    else $error("no result after end of vector");

  // the chain is empty right after a vector ends
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (valid_vec == '0) && (seen_q == '0))
    else $error("chain not cleared after end of vector");

endmodule

[rtl/core/ksel_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksel_cell
// One cell of the sorted insertion chain, with its slot of the output chain.
// ----------------------------------------------------------------------------
module ksel_cell
  import ksel_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ksel_bcast_t bcast_i,
  input  logic        en_i,              // cell lies below the effective k
  input  ksel_entry_t prev_entry_i,
  input  logic        prev_gt_i,
  input  logic        prev_mv_i,
  input  ksel_entry_t next_out_entry_i,
  input  logic        next_out_valid_i,
  output ksel_entry_t entry_o,
  output logic        gt_o,
  output logic        mv_o,
  output logic        nv_o,
  output logic        valid_o,
  output ksel_entry_t out_entry_o,
  output logic        out_valid_o
);

  ksel_entry_t entry_q, entry_d;
  logic        valid_q, valid_d;
  ksel_entry_t out_entry_q, out_entry_d;
  logic        out_valid_q, out_valid_d;
  logic        take;
  logic        load;

  // compare against the new key
  assign mv_o = valid_q & en_i;
  assign gt_o = ~mv_o | (entry_q.value > bcast_i.fresh.value);

  // this cell takes either the new entry or its neighbor's
  assign take = en_i & bcast_i.ins_en & gt_o & (~prev_gt_i | prev_mv_i);
  assign nv_o = en_i & (mv_o | take);
  assign load = bcast_i.accept & bcast_i.last;

  always_comb begin
    entry_d = entry_q;
    if (bcast_i.accept && take) begin
      entry_d = prev_gt_i ? prev_entry_i : bcast_i.fresh;
    end
  end

  // cells past k are dropped only when the item is compared; the last item clears every cell
  always_comb begin
    valid_d = valid_q;
    if (bcast_i.accept) begin
      if (bcast_i.last) begin
        valid_d = 1'b0;
      end else if (bcast_i.ins_en) begin
        valid_d = nv_o;
      end
    end
  end

  // output chain: parallel load at end of vector, shift toward cell 0 on pop
  always_comb begin
    out_entry_d = out_entry_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_entry_d = entry_d;
      out_valid_d = nv_o;
    end else if (bcast_i.pop) begin
      out_entry_d = next_out_entry_i;
      out_valid_d = next_out_valid_i;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    entry_q     <= entry_d;
    out_entry_q <= out_entry_d;
  end

  assign entry_o     = entry_q;
  assign valid_o     = valid_q;
  assign out_entry_o = out_entry_q;
  assign out_valid_o = out_valid_q;

endmodule
